FILE: rtl/core/qpd_pkg.sv
// ----------------------------------------------------------------------------
// qpd_pkg
// Types, character codes and the hex digit helper for the quoted-printable
// decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

  // Item operation codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // Escape phase codes (value 3 is unused and acts as plain text)
  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_EQ    = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  // Character codes
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [3:0] HEX_ALPHA = 4'd10;

  // Most results one item can cause
  localparam int unsigned MAX_RES = 3;

  // Input request
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } qpd_in_t;

  // Result request
  typedef struct packed {
    logic [7:0] out_byte;
    logic       invalid_hex;
    logic       last;
  } qpd_out_t;

  // Work handed from the front to the back for one item
  typedef struct packed {
    logic [1:0]               cnt;    // results to give, 1..3
    logic [MAX_RES-1:0][7:0]  bytes;  // result bytes in order
    logic                     bad;    // invalid hex, first result only
  } qpd_plan_t;

  // Hex digit value; bit 4 flags a non-hex character (value then zero)
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'd0;
    r = {1'b1, 4'd0};
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      r = {1'b0, d[3:0]};
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d = c - CH_LO_A;
      r = {1'b0, d[3:0] + HEX_ALPHA};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = c - CH_UP_A;
      r = {1'b0, d[3:0] + HEX_ALPHA};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/qpd_front.sv
// ----------------------------------------------------------------------------
// qpd_front
// Accepts encoded items, tracks escape and line state, and turns each item
// into a plan of up to three result bytes for the back end.
// ----------------------------------------------------------------------------
module qpd_front import qpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr,
  input  logic      cfg_nl_hard,
  input  logic      in_acc,
  input  qpd_in_t   in_req,
  output logic      push,
  output qpd_plan_t plan
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       nonempty_r, nonempty_nxt;
  logic       mode_r;
  logic       hard;
  logic [4:0] hex_hi, hex_lo;

  assign hex_hi = hex_decode(held_r);
  assign hex_lo = hex_decode(in_req.data_byte);

  // Classify the item and work out its results
  always_comb begin
    plan         = '0;
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    nonempty_nxt = nonempty_r;
    hard         = 1'b1;
    if (in_req.operation == OP_CHAR) begin
      nonempty_nxt = 1'b1;
      unique case (phase_r)
        PH_EQ: begin
          held_nxt  = in_req.data_byte;
          phase_nxt = PH_DIGIT;
        end
        PH_DIGIT: begin
          plan.cnt      = 2'd1;
          plan.bytes[0] = {hex_hi[3:0], hex_lo[3:0]};
          plan.bad      = hex_hi[4] | hex_lo[4];
          phase_nxt     = PH_PLAIN;
        end
        default: begin
          if (in_req.data_byte == CH_EQ) begin
            phase_nxt = PH_EQ;
          end else begin
            plan.cnt      = 2'd1;
            plan.bytes[0] = in_req.data_byte;
            phase_nxt     = PH_PLAIN;
          end
        end
      endcase
    end else begin
      if (!nonempty_r) begin
        // empty line: one newline in either mode
        plan.cnt      = 2'd1;
        plan.bytes[0] = CH_NL;
        hard          = 1'b0;
      end else begin
        unique case (phase_r)
          PH_EQ: hard = 1'b0;  // soft break
          PH_DIGIT: begin
            plan.bytes[0] = CH_EQ;
            if (held_r != CH_EQ) begin
              plan.bytes[1] = held_r;
              plan.cnt      = 2'd2;
            end else begin
              plan.cnt = 2'd1;
              hard     = 1'b0;
            end
          end
          default: plan.cnt = 2'd0;
        endcase
      end
      // optional newline at a hard line end
      if (hard && mode_r) begin
        plan.bytes[plan.cnt] = CH_NL;
        plan.cnt             = plan.cnt + 2'd1;
      end
      phase_nxt    = PH_PLAIN;
      held_nxt     = 8'd0;
      nonempty_nxt = 1'b0;
    end
  end

  assign push = in_acc && (plan.cnt != 2'd0);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PLAIN;
      held_r     <= 8'd0;
      nonempty_r <= 1'b0;
      mode_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r    <= phase_nxt;
        held_r     <= held_nxt;
        nonempty_r <= nonempty_nxt;
      end
      if (cfg_wr) begin
        mode_r <= cfg_nl_hard;
      end
    end
  end

endmodule

FILE: rtl/core/qpd_fifo.sv
// ----------------------------------------------------------------------------
// qpd_fifo
// Short plan queue between front and back so each side can stall alone.
// ----------------------------------------------------------------------------
module qpd_fifo import qpd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  qpd_plan_t push_plan,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output qpd_plan_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qpd_plan_t       slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_plan;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/qpd_back.sv
// ----------------------------------------------------------------------------
// qpd_back
// Walks the head plan one result per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module qpd_back import qpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      empty,
  input  qpd_plan_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output qpd_out_t  out_data
);

  logic [1:0] k_r;
  logic       load;
  logic       is_last;
  logic       out_valid_r;
  qpd_out_t   out_data_r;

  // Load a new result when the output register is free or being drained
  assign load    = !empty && (!out_valid_r || out_ready);
  assign is_last = (k_r == head.cnt - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        k_r         <= is_last ? 2'd0 : k_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_byte    <= head.bytes[k_r];
      out_data_r.invalid_hex <= head.bad && (k_r == 2'd0);
      out_data_r.last        <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/quoted_printable_decoder.sv
// ----------------------------------------------------------------------------
// quoted_printable_decoder
// Quoted-printable decoder: characters and line-end marks in, bytes out.
// ----------------------------------------------------------------------------
// One input request is taken per cycle while the plan queue (DEPTH entries)
// has room. Each item gives zero to three results; the output register hands
// out one result per cycle while out_ready is high and the queue is not
// empty, and items that give no results take no output slot. A result passes
// through the plan queue and then the output register. The mode register
// (cfg_data) is taken every cycle and applies to items taken later.
// ----------------------------------------------------------------------------
module quoted_printable_decoder import qpd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  qpd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output qpd_out_t out_data
);

  logic      push, pop, full, empty;
  qpd_plan_t plan, head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;

  qpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_valid),
    .cfg_nl_hard (cfg_data),
    .in_acc      (in_valid && in_ready),
    .in_req      (in_data),
    .push        (push),
    .plan        (plan)
  );

  qpd_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (plan),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  qpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/qpd_checker.sv
// ----------------------------------------------------------------------------
// qpd_checker
// Port-level checks for the quoted-printable decoder.
// ----------------------------------------------------------------------------
module qpd_checker import qpd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     cfg_valid,
  input logic     cfg_ready,
  input logic     cfg_data,
  input logic     in_valid,
  input logic     in_ready,
  input qpd_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input qpd_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request dropped or changed while stalled");

  // Nothing is shown right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result flagged invalid hex is the last result of its item
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid_hex |-> out_data.last)
    else $error("invalid hex flag on a result that is not last");

  // Configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write not taken");

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
